@@ rtl/panel_button_encoder_events_top_defines.svh @@
// assertion macros shared by the panel button and encoder event rtl
`ifndef PANEL_BUTTON_ENCODER_EVENTS_TOP_DEFINES_SVH
`define PANEL_BUTTON_ENCODER_EVENTS_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define PBE_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// property whose consequence must hold at the clock after the trigger
`define PBE_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`else
`define PBE_ASSERT(lbl, prop, msg)
`define PBE_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ rtl/pbe_pkg.sv @@
// shared widths and constants for the panel button and encoder event block
`timescale 1ns / 1ps
`default_nettype none

package pbe_pkg;

	localparam int POS_W       = 16;
	localparam int DELTA_W     = POS_W + 1;
	localparam int HOLD_W      = 8;
	localparam int NUM_ENC     = 3;
	localparam int NUM_BUTTONS = 9;

	localparam logic [HOLD_W-1:0] HOLD_RESET = HOLD_W'(80);
	localparam int HALF_RANGE = 32768;

	// bit positions of the encoders in the moved mask
	localparam int ENC_MAIN = 0;
	localparam int ENC_AUX1 = 1;
	localparam int ENC_AUX2 = 2;

endpackage

`default_nettype wire

@@ rtl/pbe_if.sv @@
// request channels of the panel button and encoder event block
`timescale 1ns / 1ps
`default_nettype none

// poll tick request: encoder positions and button levels
interface pbe_in_if #(
	parameter int NUM_BUTTONS = pbe_pkg::NUM_BUTTONS
);
	logic                      valid;
	logic                      ready;
	logic [pbe_pkg::POS_W-1:0] pos_main;
	logic [pbe_pkg::POS_W-1:0] pos_aux1;
	logic [pbe_pkg::POS_W-1:0] pos_aux2;
	logic [NUM_BUTTONS-1:0]    buttons_released;

	modport source (output valid, pos_main, pos_aux1, pos_aux2, buttons_released,
		input ready);
	modport sink (input valid, pos_main, pos_aux1, pos_aux2, buttons_released,
		output ready);
endinterface

// event report: encoder deltas and button events
interface pbe_out_if #(
	parameter int NUM_BUTTONS = pbe_pkg::NUM_BUTTONS
);
	logic                               valid;
	logic                               ready;
	logic signed [pbe_pkg::DELTA_W-1:0] delta_main;
	logic signed [pbe_pkg::DELTA_W-1:0] delta_aux1;
	logic signed [pbe_pkg::DELTA_W-1:0] delta_aux2;
	logic [pbe_pkg::NUM_ENC-1:0]        moved_mask;
	logic [NUM_BUTTONS-1:0]             tap_mask;
	logic [NUM_BUTTONS-1:0]             long_press_mask;
	logic [NUM_BUTTONS-1:0]             hold_reached_mask;
	logic                               click_level;

	modport source (output valid, delta_main, delta_aux1, delta_aux2, moved_mask,
		tap_mask, long_press_mask, hold_reached_mask, click_level, input ready);
	modport sink (input valid, delta_main, delta_aux1, delta_aux2, moved_mask,
		tap_mask, long_press_mask, hold_reached_mask, click_level, output ready);
endinterface

// configuration write request: hold length
interface pbe_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [pbe_pkg::HOLD_W-1:0] hold_ticks;

	modport source (output valid, hold_ticks, input ready);
	modport sink (input valid, hold_ticks, output ready);
endinterface

`default_nettype wire

@@ rtl/pbe_enc_lane.sv @@
// one encoder lane: last position register and wrapped signed delta
`timescale 1ns / 1ps
`default_nettype none

module pbe_enc_lane (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               en,
	input  wire logic                               primed,
	input  wire logic [pbe_pkg::POS_W-1:0]          pos,
	output logic signed [pbe_pkg::DELTA_W-1:0]      delta,
	output logic                                    moved
);

	localparam logic signed [pbe_pkg::DELTA_W-1:0] HALF =
		pbe_pkg::DELTA_W'(pbe_pkg::HALF_RANGE);

	logic [pbe_pkg::POS_W-1:0]          last_q;
	logic signed [pbe_pkg::DELTA_W-1:0] diff;
	logic                               wrap;
	logic signed [pbe_pkg::DELTA_W-1:0] wrapped;

	assign diff = $signed({1'b0, pos}) - $signed({1'b0, last_q});
	assign wrap = (diff > HALF) || (diff < -HALF);
	// adding or taking off 65536 only flips the top bit of the 17-bit difference
	assign wrapped = {diff[pbe_pkg::DELTA_W-1] ^ wrap, diff[pbe_pkg::POS_W-1:0]};

	assign moved = primed && (pos != last_q);
	assign delta = moved ? wrapped : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= '0;
		end else if (en) begin
			last_q <= pos;
		end
	end

endmodule

`default_nettype wire

@@ rtl/pbe_btn.sv @@
// button hold tracking: per-button counters, tap and long press events, click level
`timescale 1ns / 1ps
`default_nettype none
`include "panel_button_encoder_events_top_defines.svh"

module pbe_btn #(
	parameter int NUM_BUTTONS = pbe_pkg::NUM_BUTTONS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic [NUM_BUTTONS-1:0]      released,
	input  wire logic [pbe_pkg::HOLD_W-1:0]  hold_ticks,
	output logic [NUM_BUTTONS-1:0]           tap,
	output logic [NUM_BUTTONS-1:0]           long_press,
	output logic [NUM_BUTTONS-1:0]           reached,
	output logic                             click
);

	logic [NUM_BUTTONS-1:0]     held_q;
	logic [NUM_BUTTONS-1:0]     long_q;
	logic [pbe_pkg::HOLD_W-1:0] cnt_q [NUM_BUTTONS];
	logic                       click_q;

	logic [NUM_BUTTONS-1:0]     held_d;
	logic [NUM_BUTTONS-1:0]     long_d;
	logic [pbe_pkg::HOLD_W-1:0] cnt_d [NUM_BUTTONS];

	always_comb begin
		held_d     = held_q;
		long_d     = long_q;
		tap        = '0;
		long_press = '0;
		reached    = '0;
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			cnt_d[b] = cnt_q[b];
			if (released[b]) begin
				// release ends a hold; release without a hold is ignored
				if (held_q[b]) begin
					cnt_d[b]  = '0;
					held_d[b] = 1'b0;
					if (long_q[b]) begin
						long_d[b]     = 1'b0;
						long_press[b] = 1'b1;
					end else begin
						tap[b] = 1'b1;
					end
				end
			end else if (held_q[b]) begin
				// count down, stop at zero
				if (cnt_q[b] != '0) begin
					cnt_d[b] = cnt_q[b] - 1'b1;
					if (cnt_q[b] == pbe_pkg::HOLD_W'(1)) begin
						long_d[b]  = 1'b1;
						reached[b] = 1'b1;
					end
				end
			end else begin
				// press begins
				held_d[b] = 1'b1;
				cnt_d[b]  = hold_ticks;
			end
		end
	end

	// one toggle per button reaching its hold length
	assign click = click_q ^ (^reached);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			long_q  <= '0;
			click_q <= 1'b0;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				cnt_q[b] <= '0;
			end
		end else if (en) begin
			held_q  <= held_d;
			long_q  <= long_d;
			click_q <= click;
			for (int b = 0; b < NUM_BUTTONS; b++) begin
				cnt_q[b] <= cnt_d[b];
			end
		end
	end

	`PBE_ASSERT(a_long_only_while_held, (long_q & ~held_q) == '0, "long mark without hold")
	`PBE_ASSERT_NEXT(a_reached_sets_long, en && (reached != '0),
		(long_q & $past(reached)) == $past(reached), "hold reached but long mark not set")
	`PBE_ASSERT(a_tap_long_disjoint, (tap & long_press) == '0, "tap and long press together")

endmodule

`default_nettype wire

@@ rtl/panel_button_encoder_events_top.sv @@
// top level of the panel button and encoder event block
`timescale 1ns / 1ps
`default_nettype none
`include "panel_button_encoder_events_top_defines.svh"

// Panel button and encoder events. Each request on poll is one poll tick with three
// 16-bit absolute encoder positions and NUM_BUTTONS active-low button levels; each
// tick gives exactly one report. Per encoder the report carries the signed change
// since the previous tick, wrapped into -32768..32768, and a moved bit; the first
// tick after reset only records the positions and reports no motion. Per button a
// press loads a counter with hold_ticks, which counts down while the button stays
// down; the tick it reaches zero sets the hold reached bit and toggles click_level
// (once per button, so several on one tick show only their parity). Release then
// reports a long press, or a tap when the hold was shorter. hold_ticks resets to 80
// and the user must see that it is written over cfg only while the block is idle;
// the block itself does not enforce this. Zero makes every hold a tap. Throughput
// is one tick per clock while the report channel does not stall. A tick is captured
// in the input register, and the whole event evaluation is combinational from the
// input register to the report register, which drives report valid. A report
// waiting on a stalled report channel still lets the input register take one more
// tick; with both registers full the poll channel stalls until the report is taken.
module panel_button_encoder_events_top #(
	parameter int NUM_BUTTONS = pbe_pkg::NUM_BUTTONS
) (
	input wire logic clk,
	input wire logic arst_n,
	pbe_in_if.sink   poll,
	pbe_out_if.source report,
	pbe_cfg_if.sink  cfg
);

	// configuration register, always ready
	logic [pbe_pkg::HOLD_W-1:0] hold_ticks_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_ticks_q <= pbe_pkg::HOLD_RESET;
		end else if (cfg.valid) begin
			hold_ticks_q <= cfg.hold_ticks;
		end
	end

	// input register
	logic                      valid_s1;
	logic [pbe_pkg::POS_W-1:0] pos_main_s1;
	logic [pbe_pkg::POS_W-1:0] pos_aux1_s1;
	logic [pbe_pkg::POS_W-1:0] pos_aux2_s1;
	logic [NUM_BUTTONS-1:0]    rel_s1;

	// report register
	logic                               valid_s2;
	logic signed [pbe_pkg::DELTA_W-1:0] delta_main_s2;
	logic signed [pbe_pkg::DELTA_W-1:0] delta_aux1_s2;
	logic signed [pbe_pkg::DELTA_W-1:0] delta_aux2_s2;
	logic [pbe_pkg::NUM_ENC-1:0]        moved_s2;
	logic [NUM_BUTTONS-1:0]             tap_s2;
	logic [NUM_BUTTONS-1:0]             long_s2;
	logic [NUM_BUTTONS-1:0]             reached_s2;
	logic                               click_s2;

	// the tick in the input register moves on when the report register frees up;
	// state is updated at that same edge
	logic advance;
	logic primed_q;

	assign advance    = valid_s1 && (!valid_s2 || report.ready);
	assign poll.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (poll.ready) begin
			valid_s1 <= poll.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (poll.valid && poll.ready) begin
			pos_main_s1 <= poll.pos_main;
			pos_aux1_s1 <= poll.pos_aux1;
			pos_aux2_s1 <= poll.pos_aux2;
			rel_s1      <= poll.buttons_released;
		end
	end

	// first tick only records positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			primed_q <= 1'b0;
		end else if (advance) begin
			primed_q <= 1'b1;
		end
	end

	// encoder lanes
	logic signed [pbe_pkg::DELTA_W-1:0] delta_main;
	logic signed [pbe_pkg::DELTA_W-1:0] delta_aux1;
	logic signed [pbe_pkg::DELTA_W-1:0] delta_aux2;
	logic [pbe_pkg::NUM_ENC-1:0]        moved;

	pbe_enc_lane u_enc_main (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.primed (primed_q),
		.pos    (pos_main_s1),
		.delta  (delta_main),
		.moved  (moved[pbe_pkg::ENC_MAIN])
	);

	pbe_enc_lane u_enc_aux1 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.primed (primed_q),
		.pos    (pos_aux1_s1),
		.delta  (delta_aux1),
		.moved  (moved[pbe_pkg::ENC_AUX1])
	);

	pbe_enc_lane u_enc_aux2 (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.primed (primed_q),
		.pos    (pos_aux2_s1),
		.delta  (delta_aux2),
		.moved  (moved[pbe_pkg::ENC_AUX2])
	);

	// button hold tracking
	logic [NUM_BUTTONS-1:0] tap;
	logic [NUM_BUTTONS-1:0] long_press;
	logic [NUM_BUTTONS-1:0] reached;
	logic                   click;

	pbe_btn #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_btn (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.released   (rel_s1),
		.hold_ticks (hold_ticks_q),
		.tap        (tap),
		.long_press (long_press),
		.reached    (reached),
		.click      (click)
	);

	// report register: loads on advance, drains when the consumer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (report.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			delta_main_s2 <= delta_main;
			delta_aux1_s2 <= delta_aux1;
			delta_aux2_s2 <= delta_aux2;
			moved_s2      <= moved;
			tap_s2        <= tap;
			long_s2       <= long_press;
			reached_s2    <= reached;
			click_s2      <= click;
		end
	end

	assign report.valid             = valid_s2;
	assign report.delta_main        = delta_main_s2;
	assign report.delta_aux1        = delta_aux1_s2;
	assign report.delta_aux2        = delta_aux2_s2;
	assign report.moved_mask        = moved_s2;
	assign report.tap_mask          = tap_s2;
	assign report.long_press_mask   = long_s2;
	assign report.hold_reached_mask = reached_s2;
	assign report.click_level       = click_s2;

	`PBE_ASSERT(a_report_after_prime, !valid_s2 || primed_q, "report before first tick")
	`PBE_ASSERT(a_still_main_zero, !valid_s2 || moved_s2[pbe_pkg::ENC_MAIN] ||
		(delta_main_s2 == '0), "main delta without motion")
	`PBE_ASSERT_NEXT(a_stalled_report_kept, valid_s2 && !report.ready, valid_s2,
		"stalled report dropped")

endmodule

`default_nettype wire
